### rtl/core/svm_pkg.sv
// Package for the stack word machine core: payload types, opcodes, status codes,
// controller states and size constants. Used by the top level, datapath, controller and checker in rtl/core.
package svm_pkg;

	localparam int unsigned MEM_WORDS = 32768;
	localparam int unsigned MEM_AW = 15;
	localparam int unsigned STACK_DEPTH_DEF = 1024;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [15:0] load_data;
		logic [7:0]  in_char;
		logic        in_valid;
	} in_item_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_char;
		logic        consumed_input;
		logic [2:0]  status;
		logic [14:0] program_counter;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_HALT = 5'd0, OP_SET = 5'd1, OP_PUSH = 5'd2, OP_POP = 5'd3, OP_EQ = 5'd4,
		OP_GT = 5'd5, OP_JMP = 5'd6, OP_JT = 5'd7, OP_JF = 5'd8, OP_ADD = 5'd9,
		OP_MULT = 5'd10, OP_MOD = 5'd11, OP_AND = 5'd12, OP_OR = 5'd13, OP_NOT = 5'd14,
		OP_RMEM = 5'd15, OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET = 5'd18,
		OP_OUT = 5'd19, OP_IN = 5'd20, OP_NOOP = 5'd21
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_WAIT_IN = 3'd1, ST_HALTED = 3'd2, ST_POP_EMPTY = 3'd3,
		ST_RET_EMPTY = 3'd4, ST_BAD_OP = 3'd5, ST_FULL_OR_DIV0 = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_OP_WAIT, S_A_WAIT, S_B_WAIT, S_C_WAIT, S_EXEC,
		S_DIV, S_RMEM, S_RMEM_WAIT, S_STK_WAIT, S_WRITE, S_DONE
	} ctl_state_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic       capture;
		logic [2:0] mem_rd_sel;   // 0 op,1 a,2 b,3 c,4 rmem
		logic [2:0] latch_sel;    // which word register takes memory read data
		logic       latch;
		logic       div_start;
		logic       stk_rd;
		logic       stk_latch;
		logic       commit;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic       kind;
		logic       halted;
		logic [4:0] op;
		logic       op_bad;
		logic       stk_empty;
		logic       vc_zero;
		logic       div_busy;
	} dp_sts_t;

	function automatic logic [15:0] opval(input logic [15:0] w, input logic [15:0] r [8]);
		opval = w[15] ? r[w[2:0]] : w;
	endfunction

endpackage

### rtl/core/stack_vm_instruction_execute_top.sv
// Top level of the stack word machine core: controller plus datapath.
// Depends on svm_pkg, svm_ctrl and svm_datapath.
//
//   channel | direction | payload             | handshake
//   cmd     | in        | svm_pkg::in_item_t  | cmd_valid / cmd_stall
//   res     | out       | svm_pkg::out_item_t | res_valid / res_stall
//
// A load beat, or any step once halted, is handled in S_FETCH with its result beat in S_DONE;
// an instruction passes the opcode and operand read states, S_EXEC, S_WRITE and S_DONE, with
// S_RMEM for rmem, S_STK_WAIT for pop or ret with a filled stack and S_DIV for mod by a nonzero
// value while the bit-serial divider runs. The single memory port reads opcode and three
// operand words in turn. One item is in flight; cmd_stall is high until its result beat is
// taken, and the command side reopens in the cycle after that beat.
// Reset clears registers, stack pointer, program counter and halt flag; memory is not cleared.
module stack_vm_instruction_execute_top #(
	parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  svm_pkg::in_item_t  cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output svm_pkg::out_item_t res
);
	svm_pkg::dp_cmd_t dp_cmd;
	svm_pkg::dp_sts_t dp_sts;
	logic busy;

	assign cmd_stall = busy;

	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_beat(cmd_valid && !busy),
		.out_beat(res_valid && !res_stall), .sts(dp_sts), .cmd(dp_cmd),
		.busy(busy), .res_valid(res_valid)
	);

	svm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(cmd), .cmd(dp_cmd), .sts(dp_sts), .result(res)
	);
endmodule

### rtl/core/svm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module svm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### rtl/core/svm_div.sv
// Bit-serial restoring divider giving the remainder of two 16-bit words.
// No dependencies.
module svm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] remainder
);
	logic [4:0]  cnt_q;
	logic [15:0] num_q;
	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [16:0] trial;

	assign trial = {rem_q, num_q[15]} - {1'b0, den_q};
	assign busy = (cnt_q != 5'd0);
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// When the trial subtraction borrows, the shifted remainder is below the divisor
	// and so fits in 16 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[14:0], 1'b0};
			rem_q <= trial[16] ? {rem_q[14:0], num_q[15]} : trial[15:0];
		end
	end
endmodule

### rtl/core/svm_datapath.sv
// Datapath: main memory and stack RAMs, register file, operand words, ALU,
// divider and result register. Depends on svm_pkg, svm_ram and svm_div.
module svm_datapath #(
	parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  svm_pkg::in_item_t   item,
	input  svm_pkg::dp_cmd_t    cmd,
	output svm_pkg::dp_sts_t    sts,
	output svm_pkg::out_item_t  result
);
	localparam int unsigned SAW = $clog2(STACK_DEPTH);
	localparam int unsigned SCW = SAW + 1;

	svm_pkg::in_item_t item_q;
	logic [15:0] regs_q [8];
	logic [14:0] ip_q;
	logic        halted_q;
	logic [SCW-1:0] sp_q;
	logic [15:0] op_q, a_q, b_q, c_q, rm_q, stk_q;
	svm_pkg::out_item_t res_q;

	logic [15:0] va, vb, vc;
	assign va = svm_pkg::opval(a_q, regs_q);
	assign vb = svm_pkg::opval(b_q, regs_q);
	assign vc = svm_pkg::opval(c_q, regs_q);

	// Memory port.
	logic        mem_we;
	logic [14:0] mem_addr;
	logic [15:0] mem_wdata, mem_rdata;
	logic        stk_we;
	logic [SAW-1:0] stk_addr;
	logic [15:0] stk_wdata, stk_rdata;

	logic        div_busy;
	logic [15:0] div_rem;

	// Commit decode.
	logic        dw_en;
	logic [15:0] dw_val;
	logic [14:0] next_ip;
	logic        wm_en;
	logic [14:0] wm_addr;
	logic [15:0] wm_val;
	logic [2:0]  err;
	logic        push_en, pop_en;
	logic [15:0] push_val;
	logic [14:0] p1, p2, p3, p4;
	logic [29:0] prod;

	assign p1 = ip_q + 15'd1;
	assign p2 = ip_q + 15'd2;
	assign p3 = ip_q + 15'd3;
	assign p4 = ip_q + 15'd4;
	assign prod = vb[14:0] * vc[14:0];

	always_comb begin
		dw_en = 1'b0; dw_val = '0; next_ip = ip_q; wm_en = 1'b0; wm_addr = '0; wm_val = '0;
		err = svm_pkg::ST_OK; push_en = 1'b0; pop_en = 1'b0; push_val = '0;
		case (op_q[4:0])
			svm_pkg::OP_HALT: err = svm_pkg::ST_HALTED;
			svm_pkg::OP_SET: begin dw_en = 1'b1; dw_val = vb; next_ip = p3; end
			svm_pkg::OP_PUSH: begin
				if (sp_q >= SCW'(STACK_DEPTH)) err = svm_pkg::ST_FULL_OR_DIV0;
				else begin push_en = 1'b1; push_val = va; next_ip = p2; end
			end
			svm_pkg::OP_POP: begin
				if (sp_q == '0) err = svm_pkg::ST_POP_EMPTY;
				else begin pop_en = 1'b1; dw_en = 1'b1; dw_val = stk_q; next_ip = p2; end
			end
			svm_pkg::OP_EQ: begin dw_en = 1'b1; dw_val = {15'd0, vb == vc}; next_ip = p4; end
			svm_pkg::OP_GT: begin dw_en = 1'b1; dw_val = {15'd0, vb > vc}; next_ip = p4; end
			svm_pkg::OP_JMP: next_ip = va[14:0];
			svm_pkg::OP_JT: next_ip = (va != '0) ? vb[14:0] : p3;
			svm_pkg::OP_JF: next_ip = (va == '0) ? vb[14:0] : p3;
			svm_pkg::OP_ADD: begin
				dw_en = 1'b1; dw_val = {1'b0, vb[14:0] + vc[14:0]}; next_ip = p4;
			end
			svm_pkg::OP_MULT: begin dw_en = 1'b1; dw_val = {1'b0, prod[14:0]}; next_ip = p4; end
			svm_pkg::OP_MOD: begin
				if (vc == '0) err = svm_pkg::ST_FULL_OR_DIV0;
				else begin dw_en = 1'b1; dw_val = div_rem; next_ip = p4; end
			end
			svm_pkg::OP_AND: begin dw_en = 1'b1; dw_val = vb & vc; next_ip = p4; end
			svm_pkg::OP_OR: begin dw_en = 1'b1; dw_val = vb | vc; next_ip = p4; end
			svm_pkg::OP_NOT: begin dw_en = 1'b1; dw_val = {1'b0, ~vb[14:0]}; next_ip = p3; end
			svm_pkg::OP_RMEM: begin dw_en = 1'b1; dw_val = rm_q; next_ip = p3; end
			svm_pkg::OP_WMEM: begin wm_en = 1'b1; wm_addr = va[14:0]; wm_val = vb; next_ip = p3; end
			svm_pkg::OP_CALL: begin
				if (sp_q >= SCW'(STACK_DEPTH)) err = svm_pkg::ST_FULL_OR_DIV0;
				else begin push_en = 1'b1; push_val = {1'b0, p2}; next_ip = va[14:0]; end
			end
			svm_pkg::OP_RET: begin
				if (sp_q == '0) err = svm_pkg::ST_RET_EMPTY;
				else begin pop_en = 1'b1; next_ip = stk_q[14:0]; end
			end
			svm_pkg::OP_OUT: next_ip = p2;
			svm_pkg::OP_IN: begin
				if (item_q.in_valid) begin
					dw_en = 1'b1; dw_val = {8'd0, item_q.in_char}; next_ip = p2;
				end
			end
			svm_pkg::OP_NOOP: next_ip = p1;
			default: err = svm_pkg::ST_BAD_OP;
		endcase
		if (op_q[15:5] != '0) begin
			err = svm_pkg::ST_BAD_OP; dw_en = 1'b0; wm_en = 1'b0; push_en = 1'b0; pop_en = 1'b0;
		end
	end

	logic is_load, commit_x;
	assign is_load = (item_q.kind == 1'b0);
	assign commit_x = cmd.commit && !is_load;

	always_comb begin
		mem_we = 1'b0; mem_wdata = '0;
		case (cmd.mem_rd_sel)
			3'd0: mem_addr = ip_q;
			3'd1: mem_addr = p1;
			3'd2: mem_addr = p2;
			3'd3: mem_addr = p3;
			default: mem_addr = vb[14:0];
		endcase
		if (cmd.commit) begin
			if (is_load) begin
				mem_we = ~item_q.address[15]; mem_addr = item_q.address[14:0];
				mem_wdata = item_q.load_data;
			end else if (wm_en) begin
				mem_we = 1'b1; mem_addr = wm_addr; mem_wdata = wm_val;
			end else if (dw_en && !a_q[15]) begin
				mem_we = 1'b1; mem_addr = a_q[14:0]; mem_wdata = dw_val;
			end
		end
	end

	assign stk_we = commit_x && push_en;
	assign stk_addr = stk_we ? sp_q[SAW-1:0] : SAW'(sp_q - SCW'(1));
	assign stk_wdata = push_val;

	svm_ram #(.WIDTH(16), .DEPTH(svm_pkg::MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
	);
	svm_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
	);
	svm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(vb), .divisor(vc),
		.busy(div_busy), .remainder(div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= item;
		if (cmd.latch) begin
			case (cmd.latch_sel)
				3'd0: op_q <= mem_rdata;
				3'd1: a_q <= mem_rdata;
				3'd2: b_q <= mem_rdata;
				3'd3: c_q <= mem_rdata;
				default: rm_q <= mem_rdata;
			endcase
		end
		if (cmd.stk_latch)
			stk_q <= stk_rdata;
	end

	logic waiting;
	assign waiting = (op_q == 16'(svm_pkg::OP_IN)) && !item_q.in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs_q[i] <= '0;
			ip_q <= '0;
			halted_q <= 1'b0;
			sp_q <= '0;
		end else if (cmd.commit) begin
			if (is_load) begin
				if (item_q.address[15] && item_q.address[14:3] == '0)
					regs_q[item_q.address[2:0]] <= item_q.load_data;
			end else if (err != svm_pkg::ST_OK) begin
				halted_q <= 1'b1;
			end else begin
				ip_q <= next_ip;
				if (dw_en && a_q[15])
					regs_q[a_q[2:0]] <= dw_val;
				if (push_en) sp_q <= sp_q + SCW'(1);
				if (pop_en) sp_q <= sp_q - SCW'(1);
			end
		end
	end

	// Result built at commit from pre-commit state; the halted case bypasses commit.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.out_valid <= 1'b0;
			res_q.out_char <= '0;
			res_q.consumed_input <= 1'b0;
			res_q.status <= halted_q ? svm_pkg::ST_HALTED : svm_pkg::ST_OK;
			res_q.program_counter <= ip_q;
		end else if (cmd.commit) begin
			res_q.out_valid <= 1'b0;
			res_q.out_char <= '0;
			res_q.consumed_input <= 1'b0;
			if (is_load) begin
				res_q.status <= halted_q ? svm_pkg::ST_HALTED : svm_pkg::ST_OK;
				res_q.program_counter <= ip_q;
			end else if (err != svm_pkg::ST_OK) begin
				res_q.status <= err;
				res_q.program_counter <= ip_q;
			end else begin
				res_q.status <= waiting ? svm_pkg::ST_WAIT_IN : svm_pkg::ST_OK;
				res_q.program_counter <= next_ip;
				res_q.out_valid <= (op_q == 16'(svm_pkg::OP_OUT));
				res_q.out_char <= (op_q == 16'(svm_pkg::OP_OUT)) ? va[7:0] : 8'd0;
				res_q.consumed_input <= (op_q == 16'(svm_pkg::OP_IN)) && item_q.in_valid;
			end
		end
	end
	assign result = res_q;

	assign sts.kind = item_q.kind;
	assign sts.halted = halted_q;
	assign sts.op = op_q[4:0];
	assign sts.op_bad = (op_q[15:5] != '0) || (op_q[4:0] > 5'd21);
	assign sts.stk_empty = (sp_q == '0);
	assign sts.vc_zero = (vc == '0);
	assign sts.div_busy = div_busy;
endmodule

### rtl/core/svm_ctrl.sv
// Controller state machine sequencing fetch, operand reads and commit.
// Depends on svm_pkg.
module svm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_beat,
	input  logic               out_beat,
	input  svm_pkg::dp_sts_t   sts,
	output svm_pkg::dp_cmd_t   cmd,
	output logic               busy,
	output logic               res_valid
);
	svm_pkg::ctl_state_t state_q, state_d;
	logic [2:0] rd_q, rd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svm_pkg::S_IDLE;
			rd_q <= '0;
		end else begin
			state_q <= state_d;
			rd_q <= rd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_d = rd_q;
		cmd = '0;
		busy = 1'b1;
		res_valid = 1'b0;
		case (state_q)
			svm_pkg::S_IDLE: begin
				busy = 1'b0;
				cmd.capture = in_beat;
				if (in_beat) state_d = svm_pkg::S_FETCH;
			end
			svm_pkg::S_FETCH: begin
				if (!sts.kind) begin
					cmd.commit = 1'b1;
					state_d = svm_pkg::S_DONE;
				end else if (sts.halted) begin
					cmd.emit = 1'b1;
					state_d = svm_pkg::S_DONE;
				end else begin
					// Read opcode and the three operand words back to back.
					cmd.mem_rd_sel = 3'd0;
					rd_d = 3'd0;
					state_d = svm_pkg::S_OP_WAIT;
				end
			end
			svm_pkg::S_OP_WAIT, svm_pkg::S_A_WAIT, svm_pkg::S_B_WAIT, svm_pkg::S_C_WAIT: begin
				cmd.latch = 1'b1;
				cmd.latch_sel = rd_q;
				cmd.mem_rd_sel = rd_q + 3'd1;
				rd_d = rd_q + 3'd1;
				case (state_q)
					svm_pkg::S_OP_WAIT: state_d = svm_pkg::S_A_WAIT;
					svm_pkg::S_A_WAIT: state_d = svm_pkg::S_B_WAIT;
					svm_pkg::S_B_WAIT: state_d = svm_pkg::S_C_WAIT;
					default: state_d = svm_pkg::S_EXEC;
				endcase
			end
			svm_pkg::S_EXEC: begin
				if (sts.op_bad) state_d = svm_pkg::S_WRITE;
				else if (sts.op == svm_pkg::OP_MOD && !sts.vc_zero) begin
					cmd.div_start = 1'b1;
					state_d = svm_pkg::S_DIV;
				end else if (sts.op == svm_pkg::OP_RMEM) begin
					cmd.mem_rd_sel = 3'd4;
					state_d = svm_pkg::S_RMEM;
				end else if ((sts.op == svm_pkg::OP_POP || sts.op == svm_pkg::OP_RET)
						&& !sts.stk_empty) begin
					state_d = svm_pkg::S_STK_WAIT;
				end else state_d = svm_pkg::S_WRITE;
			end
			svm_pkg::S_DIV: if (!sts.div_busy) state_d = svm_pkg::S_WRITE;
			svm_pkg::S_RMEM: begin
				cmd.mem_rd_sel = 3'd4;
				cmd.latch = 1'b1;
				cmd.latch_sel = 3'd4;
				state_d = svm_pkg::S_WRITE;
			end
			svm_pkg::S_STK_WAIT: begin
				cmd.stk_latch = 1'b1;
				state_d = svm_pkg::S_WRITE;
			end
			svm_pkg::S_WRITE: begin
				cmd.commit = 1'b1;
				state_d = svm_pkg::S_DONE;
			end
			svm_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (out_beat) state_d = svm_pkg::S_IDLE;
			end
			default: state_d = svm_pkg::S_IDLE;
		endcase
	end
endmodule

### rtl/core/svm_checker.sv
// Port-level checker for the stack word machine core, bound to the top level.
// Depends on svm_pkg.
module svm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input svm_pkg::out_item_t res
);
	// A result never appears in the cycle right after its command beat.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> !res_valid) else $error("early result");
	// The input side is closed while a result waits.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cmd_stall) else $error("second item taken");
	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res)) else $error("result changed");
	// Status codes above the last defined one never appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status != 3'd7) else $error("bad status");
endmodule

bind stack_vm_instruction_execute_top svm_checker u_svm_checker (
	.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
	.res_valid(res_valid), .res_stall(res_stall), .res(res)
);
